[sv/hta_pkg.sv]
// Shared types, codes and defaults for the handle table allocator.
package hta_pkg;

  localparam int NUM_ROWS_DEFAULT      = 32;
  localparam int SLOTS_PER_ROW_DEFAULT = 32;
  localparam int VALUE_WIDTH_DEFAULT   = 32;
  localparam int QUEUE_DEPTH           = 2;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_LOOKUP,
    OP_FREE,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PICK,
    BK_COMMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  handle_row;
    logic [4:0]  handle_col;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  result_row;
    logic [4:0]  result_col;
    logic [31:0] read_value;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
  } cmd_t;

endpackage

[sv/hta_front.sv]
// Front end: accepts request items and classifies them into commands.
module hta_front #(
  parameter int NUM_ROWS      = hta_pkg::NUM_ROWS_DEFAULT,
  parameter int SLOTS_PER_ROW = hta_pkg::SLOTS_PER_ROW_DEFAULT
) (
  input  logic          req_valid,
  output logic          req_ready,
  input  hta_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output hta_pkg::cmd_t cmd
);
  import hta_pkg::*;

  logic handle_ok;

  assign handle_ok = ({1'b0, req.handle_row} < 6'(NUM_ROWS)) &&
                     ({1'b0, req.handle_col} < 6'(SLOTS_PER_ROW));

  assign cmd_valid = req_valid;
  assign req_ready = cmd_ready;

  always_comb begin
    cmd.row   = req.handle_row;
    cmd.col   = req.handle_col;
    cmd.value = req.entry_value;
    case (req.kind)
      KIND_ALLOC:  cmd.op = OP_ALLOC;
      KIND_LOOKUP: cmd.op = handle_ok ? OP_LOOKUP : OP_REJECT;
      KIND_FREE:   cmd.op = handle_ok ? OP_FREE : OP_REJECT;
      default:     cmd.op = OP_REJECT;
    endcase
  end

endmodule

[sv/hta_queue.sv]
// Small command queue between the front end and the back end.
module hta_queue #(
  parameter int DEPTH = hta_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  hta_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hta_pkg::cmd_t pop_cmd
);
  import hta_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/hta_back.sv]
// Back end: bitmaps, value memory and the pick/commit sequencer.
module hta_back #(
  parameter int NUM_ROWS      = hta_pkg::NUM_ROWS_DEFAULT,
  parameter int SLOTS_PER_ROW = hta_pkg::SLOTS_PER_ROW_DEFAULT,
  parameter int VALUE_WIDTH   = hta_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  hta_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output hta_pkg::rsp_t rsp
);
  import hta_pkg::*;

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W  = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
  localparam int DEPTH  = NUM_ROWS * SLOTS_PER_ROW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t state;
  back_state_t state_next;

  logic [SLOTS_PER_ROW-1:0] used_map [NUM_ROWS];
  logic [NUM_ROWS-1:0]      in_use;
  logic [VALUE_WIDTH-1:0]   mem [DEPTH];

  cmd_t                     cur;
  logic [ROW_W-1:0]         cur_row;
  logic [COL_W-1:0]         cur_col;
  logic [ROW_W-1:0]         pick_row;
  logic [SLOTS_PER_ROW-1:0] pick_word;
  logic                     pick_found;
  logic [VALUE_WIDTH-1:0]   rd_data;

  logic [NUM_ROWS-1:0]      row_open;
  logic [ROW_W-1:0]         enc_row;
  logic                     enc_found;
  logic [ROW_W-1:0]         sel_row;
  logic [COL_W-1:0]         alloc_col;
  logic                     hit;
  logic [SLOTS_PER_ROW-1:0] free_mask;
  logic                     can_commit;
  logic                     pop;
  logic                     rd_en;
  logic                     commit;
  logic                     alloc_ok;
  logic                     free_ok;
  logic [ADDR_W-1:0]        raddr;
  logic [ADDR_W-1:0]        waddr;
  logic [VALUE_WIDTH+31:0]  wext;
  logic [VALUE_WIDTH+31:0]  rext;
  rsp_t                     rsp_next;

  assign cur_row = cur.row[ROW_W-1:0];
  assign cur_col = cur.col[COL_W-1:0];

  // Pick cycle: find the first row that is not in use or not full; a lookup or free uses its own row.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_open[r] = !in_use[r] || !(&used_map[r]);
    end
    enc_row   = '0;
    enc_found = 1'b0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (row_open[r]) begin
        enc_row   = ROW_W'(r);
        enc_found = 1'b1;
      end
    end
    sel_row = (cur.op == OP_LOOKUP || cur.op == OP_FREE) ? cur_row : enc_row;
  end

  // Commit cycle: lowest free column of the picked row.
  always_comb begin
    alloc_col = '0;
    for (int c = SLOTS_PER_ROW - 1; c >= 0; c--) begin
      if (!pick_word[c]) begin
        alloc_col = COL_W'(c);
      end
    end
  end

  assign hit       = pick_word[cur_col];
  assign free_mask = pick_word & ~(SLOTS_PER_ROW'(1) << cur_col);
  assign raddr     = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(SLOTS_PER_ROW) + ADDR_W'(cur_col));
  assign waddr     = ADDR_W'(ADDR_W'(pick_row) * ADDR_W'(SLOTS_PER_ROW) + ADDR_W'(alloc_col));
  assign wext      = {{VALUE_WIDTH{1'b0}}, cur.value};
  assign rext      = {32'b0, rd_data};

  assign can_commit = !rsp_valid || rsp_ready;
  assign alloc_ok   = (cur.op == OP_ALLOC) && pick_found;
  assign free_ok    = (cur.op == OP_FREE) && hit;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (cmd_valid) state_next = BK_PICK;
      BK_PICK:   state_next = BK_COMMIT;
      BK_COMMIT: begin
        if (can_commit) begin
          state_next = cmd_valid ? BK_PICK : BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    rd_en  = 1'b0;
    commit = 1'b0;
    case (state)
      BK_IDLE:   pop = cmd_valid;
      BK_PICK:   rd_en = 1'b1;
      BK_COMMIT: begin
        commit = can_commit;
        pop    = can_commit && cmd_valid;
      end
      default:   pop = 1'b0;
    endcase
  end

  assign cmd_ready = pop;

  always_comb begin
    rsp_next.status     = STATUS_FAIL;
    rsp_next.result_row = '0;
    rsp_next.result_col = '0;
    rsp_next.read_value = '0;
    case (cur.op)
      OP_ALLOC: begin
        if (pick_found) begin
          rsp_next.status     = STATUS_OK;
          rsp_next.result_row = 5'(pick_row);
          rsp_next.result_col = 5'(alloc_col);
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          rsp_next.status     = STATUS_OK;
          rsp_next.read_value = rext[31:0];
        end
      end
      OP_FREE: begin
        if (hit) rsp_next.status = STATUS_OK;
      end
      default: rsp_next.status = STATUS_FAIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (rd_en) begin
      pick_row   <= sel_row;
      pick_word  <= used_map[sel_row];
      pick_found <= enc_found;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && alloc_ok) begin
      mem[waddr] <= wext[VALUE_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        used_map[r] <= '0;
      end
      in_use <= NUM_ROWS'(1);
    end else if (commit) begin
      if (alloc_ok) begin
        used_map[pick_row][alloc_col] <= 1'b1;
        in_use[pick_row]              <= 1'b1;
      end else if (free_ok) begin
        used_map[pick_row][cur_col] <= 1'b0;
        if (free_mask == '0) begin
          in_use[pick_row] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

[sv/handle_table_allocator.sv]
// Handle table allocator top level: front end, command queue and back end.
// Each request item yields exactly one response item, in order. The back end
// handles each item in a pick state (row priority encode over the row
// bitmaps and the value memory read) and then a commit state (column priority
// encode, value memory write, bitmap update and response register load); it
// holds in commit while a response waits to be taken, and takes another item
// only as it commits the current one. A request passes the queue, the command
// register, the pick registers and the response register. A two-entry queue
// keeps requests flowing while a response waits to be taken. The value memory
// needs no clearing after reset; a value is only read through a used slot.
module handle_table_allocator #(
  parameter int NUM_ROWS      = hta_pkg::NUM_ROWS_DEFAULT,
  parameter int SLOTS_PER_ROW = hta_pkg::SLOTS_PER_ROW_DEFAULT,
  parameter int VALUE_WIDTH   = hta_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  hta_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output hta_pkg::rsp_t rsp
);
  import hta_pkg::*;

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  hta_front #(
    .NUM_ROWS      (NUM_ROWS),
    .SLOTS_PER_ROW (SLOTS_PER_ROW)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  hta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  hta_back #(
    .NUM_ROWS      (NUM_ROWS),
    .SLOTS_PER_ROW (SLOTS_PER_ROW),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

[sv/hta_checker.sv]
// Port-level checker for the handle table allocator, with its bind.
module hta_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input hta_pkg::rsp_t rsp
);
  import hta_pkg::*;

  // No response item can be pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A failed operation returns an all-zero handle and value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_FAIL |->
      rsp.result_row == '0 && rsp.result_col == '0 && rsp.read_value == '0)
    else $error("failed response carries data");

  // A nonzero value only comes from a successful lookup, which has no handle.
  a_value_lookup: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_value != '0 |->
      rsp.status == STATUS_OK && rsp.result_row == '0 && rsp.result_col == '0)
    else $error("read value with allocate handle");

  // The first item after reset is one request, so no response can be valid
  // in the cycle after the first accept.
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !rsp_valid && req_valid && req_ready |=> !rsp_valid)
    else $error("response too early after reset");

endmodule

bind handle_table_allocator hta_checker u_hta_checker (.*);

[test/testbench.sv]
// Testbench for the handle table allocator: directed table plus random traffic checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import hta_pkg::*;

  localparam int NUM_ROWS      = NUM_ROWS_DEFAULT;
  localparam int SLOTS_PER_ROW = SLOTS_PER_ROW_DEFAULT;
  localparam int NUM_SLOTS     = NUM_ROWS * SLOTS_PER_ROW;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int IDLE_PERCENT  = 12;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    req_t item;
    bit   typed;
    rsp_t want;
  } directed_t;

  localparam int NUM_DIRECTED = 22;
  localparam directed_t DIRECTED [NUM_DIRECTED] = '{
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'hFFFF_FFFF}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'h0000_0000}, 1'b1, {STATUS_OK,   5'd0, 5'd1, 32'd0}},
    '{{KIND_LOOKUP,  5'd0,  5'd0,  32'h0000_0000}, 1'b1,
      {STATUS_OK, 5'd0, 5'd0, 32'hFFFF_FFFF}},
    '{{KIND_LOOKUP,  5'd0,  5'd1,  32'hFFFF_FFFF}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_LOOKUP,  5'd31, 5'd31, 32'hFFFF_FFFF}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_LOOKUP,  5'd0,  5'd2,  32'h0000_0000}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd0,  32'h0000_0000}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd0,  32'hFFFF_FFFF}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_LOOKUP,  5'd0,  5'd0,  32'h0000_0000}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_UNKNOWN, 5'd31, 5'd31, 32'hFFFF_FFFF}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'h0000_FFFF}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_LOOKUP,  5'd0,  5'd0,  32'h0000_0000}, 1'b0, '0},
    '{{KIND_FREE,    5'd31, 5'd0,  32'h0000_0000}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd31, 32'h0000_0000}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd1,  32'h0000_0000}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd0,  32'h0000_0000}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'hA5A5_A5A5}, 1'b1, {STATUS_OK,   5'd0, 5'd0, 32'd0}},
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'h5A5A_5A5A}, 1'b0, '0},
    '{{KIND_LOOKUP,  5'd0,  5'd1,  32'h0000_0000}, 1'b0, '0},
    '{{KIND_UNKNOWN, 5'd0,  5'd0,  32'h0000_0000}, 1'b1, {STATUS_FAIL, 5'd0, 5'd0, 32'd0}},
    '{{KIND_FREE,    5'd0,  5'd0,  32'h0000_0000}, 1'b0, '0},
    '{{KIND_ALLOC,   5'd0,  5'd0,  32'h1234_5678}, 1'b0, '0}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Predictor state: mirrors the table after every accepted item.
  logic [NUM_ROWS-1:0]      row_busy;
  logic [SLOTS_PER_ROW-1:0] slot_busy [NUM_ROWS];
  logic [31:0]              slot_data [NUM_SLOTS];
  int                       slots_taken;

  rsp_t pending_replies [$];
  int   mismatches;
  int   cycle_count;
  bit   steady;

  // Stimulus steering for the random part.
  bit   filling;
  int   full_streak;
  int   drain_row;

  handle_table_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic rsp_t allocator_reply(input req_t item);
    rsp_t reply;
    bit   found;
    int   r;
    int   c;
    reply = '0;
    reply.status = STATUS_FAIL;
    found = 1'b0;
    c = 0;
    case (item.kind)
      KIND_ALLOC: begin
        for (r = 0; r < NUM_ROWS && !found; r++) begin
          if (!row_busy[r]) begin
            row_busy[r] = 1'b1;
            c = 0;
            found = 1'b1;
          end else if (slot_busy[r] != '1) begin
            for (c = 0; c < SLOTS_PER_ROW; c++) begin
              if (!slot_busy[r][c]) begin
                found = 1'b1;
                break;
              end
            end
          end
          if (found) begin
            slot_busy[r][c] = 1'b1;
            slot_data[r * SLOTS_PER_ROW + c] = item.entry_value;
            slots_taken++;
            reply.status = STATUS_OK;
            reply.result_row = r[4:0];
            reply.result_col = c[4:0];
          end
        end
      end
      KIND_LOOKUP: begin
        if (slot_busy[item.handle_row][item.handle_col]) begin
          reply.status = STATUS_OK;
          reply.read_value = slot_data[item.handle_row * SLOTS_PER_ROW + item.handle_col];
        end
      end
      KIND_FREE: begin
        if (slot_busy[item.handle_row][item.handle_col]) begin
          reply.status = STATUS_OK;
          slot_busy[item.handle_row][item.handle_col] = 1'b0;
          slots_taken--;
          if (slot_busy[item.handle_row] == '0) row_busy[item.handle_row] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Picks a random taken slot, or a random handle when the table is empty.
  function automatic void pick_taken(output logic [4:0] row, output logic [4:0] col);
    int start;
    int k;
    int idx;
    row = 5'($urandom);
    col = 5'($urandom);
    start = $urandom_range(NUM_SLOTS - 1);
    for (k = 0; k < NUM_SLOTS; k++) begin
      idx = (start + k) % NUM_SLOTS;
      if (slot_busy[idx / SLOTS_PER_ROW][idx % SLOTS_PER_ROW]) begin
        row = 5'(idx / SLOTS_PER_ROW);
        col = 5'(idx % SLOTS_PER_ROW);
        return;
      end
    end
  endfunction

  // While draining, frees are aimed at one row at a time so rows empty out.
  function automatic void pick_drain_slot(output logic [4:0] row, output logic [4:0] col);
    int start;
    int k;
    if (slot_busy[drain_row] == '0) begin
      pick_taken(row, col);
      drain_row = row;
    end
    row = 5'(drain_row);
    col = 5'($urandom);
    start = $urandom_range(SLOTS_PER_ROW - 1);
    for (k = 0; k < SLOTS_PER_ROW; k++) begin
      if (slot_busy[drain_row][(start + k) % SLOTS_PER_ROW]) begin
        col = 5'((start + k) % SLOTS_PER_ROW);
        return;
      end
    end
  endfunction

  function automatic req_t random_item();
    req_t item;
    int   roll;
    item.kind = KIND_ALLOC;
    item.handle_row = 5'($urandom);
    item.handle_col = 5'($urandom);
    item.entry_value = $urandom;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 88) begin
        item.kind = KIND_ALLOC;
      end else if (roll < 92) begin
        item.kind = KIND_LOOKUP;
        pick_taken(item.handle_row, item.handle_col);
      end else if (roll < 94) begin
        item.kind = KIND_FREE;
        pick_taken(item.handle_row, item.handle_col);
      end else if (roll < 96) begin
        item.kind = KIND_LOOKUP;
      end else if (roll < 98) begin
        item.kind = KIND_FREE;
      end else begin
        item.kind = KIND_UNKNOWN;
      end
    end else begin
      if (roll < 10) begin
        item.kind = KIND_ALLOC;
      end else if (roll < 60) begin
        item.kind = KIND_FREE;
        pick_drain_slot(item.handle_row, item.handle_col);
      end else if (roll < 72) begin
        item.kind = KIND_LOOKUP;
        pick_taken(item.handle_row, item.handle_col);
      end else if (roll < 84) begin
        item.kind = KIND_FREE;
      end else if (roll < 94) begin
        item.kind = KIND_LOOKUP;
      end else begin
        item.kind = KIND_UNKNOWN;
      end
    end
    return item;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input req_t item, input bit typed, input rsp_t want);
    rsp_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    predicted = allocator_reply(item);
    pending_replies.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(negedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    rsp_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected reply, status", '0, 32'(rsp.status));
      end else begin
        want = pending_replies.pop_front();
        if (rsp.status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(rsp.status));
        if (rsp.result_row !== want.result_row)
          note_mismatch("result_row", 32'(want.result_row), 32'(rsp.result_row));
        if (rsp.result_col !== want.result_col)
          note_mismatch("result_col", 32'(want.result_col), 32'(rsp.result_col));
        if (rsp.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, rsp.read_value);
      end
    end
  end

  initial begin
    int n;
    int r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    steady = 1'b0;
    filling = 1'b1;
    full_streak = 0;
    drain_row = 0;
    row_busy = '0;
    row_busy[0] = 1'b1;
    for (r = 0; r < NUM_ROWS; r++) slot_busy[r] = '0;
    slots_taken = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_item(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].want);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 700);
      // Stay at a full table for a while so allocation failures are seen.
      if (filling && slots_taken == NUM_SLOTS) begin
        full_streak++;
        if (full_streak > 15) begin
          filling = 1'b0;
          full_streak = 0;
        end
      end else if (!filling && slots_taken < 8) begin
        filling = 1'b1;
      end
      send_item(random_item(), 1'b0, '0);
    end
    req_valid <= 1'b0;
    steady = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
sv/hta_pkg.sv
sv/hta_front.sv
sv/hta_queue.sv
sv/hta_back.sv
sv/handle_table_allocator.sv
sv/hta_checker.sv
test/testbench.sv
